FILE: hdl/mcpwc_pkg.sv
// Shared constants, codes and types for the pulse width capture core.
package mcpwc_pkg;

    localparam int CHANNELS      = 8;
    localparam int FRAME_SLOTS   = 8;
    localparam int COUNTS_PER_US = 72;
    localparam int LANES         = 8;

    localparam int NCH = (CHANNELS < LANES) ? CHANNELS : LANES;
    localparam logic [LANES-1:0] CHAN_MASK = LANES'((1 << NCH) - 1);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / 64'(COUNTS_PER_US));
    localparam logic [31:0] DIV1  = 32'(COUNTS_PER_US);
    localparam logic [31:0] DIV2  = 32'(2 * COUNTS_PER_US);
    localparam logic [31:0] DIV3  = 32'(3 * COUNTS_PER_US);
    localparam logic [4:0]  SLOT_LIMIT = 5'(FRAME_SLOTS);

    // quotient and remainder of the all-ones upper word when a span underflows
    localparam logic [31:0] WRAP_Q = 32'(64'hFFFF_FFFF_0000_0000 / 64'(COUNTS_PER_US));
    localparam logic [31:0] WRAP_R = 32'(64'hFFFF_FFFF_0000_0000 % 64'(COUNTS_PER_US));

    localparam logic KIND_HIGH = 1'b0;
    localparam logic KIND_SLOT = 1'b1;

    localparam logic CFG_TIMER_PERIOD = 1'b0;
    localparam logic CFG_SYNC_GAP     = 1'b1;

    localparam logic [31:0] TIMER_PERIOD_RST = 32'hFFFF_FFFF;
    localparam logic [15:0] SYNC_GAP_RST     = 16'd2500;

    typedef struct packed {
        logic        kind;
        logic [2:0]  channel;
        logic [31:0] start;
        logic [31:0] now;
        logic        last;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

FILE: hdl/mcpwc_front.sv
// Front end: accepts edge events, updates start times, emits one measurement op per cycle while the queue is not full.
module mcpwc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [47:0]     s_tdata,
    output mcpwc_pkg::op_t  op,
    output logic            op_push,
    input  mcpwc_pkg::qstat_t qstat
);
    import mcpwc_pkg::*;

    logic [31:0]      start_reg [LANES];
    logic [31:0]      start_next [LANES];
    logic             hold_valid_reg, hold_valid_next;
    logic [LANES-1:0] pend_reg, pend_next;
    logic [31:0]      now_reg, now_next;
    logic [31:0]      start0_reg, start0_next;
    logic             rise0_reg, rise0_next;

    logic [31:0]      ts;
    logic [LANES-1:0] chg, lvl, res_in, rise_in, pick, left;
    logic [2:0]       chan;
    logic             accept;

    always_comb begin
        ts      = s_tdata[31:0];
        chg     = s_tdata[39:32];
        lvl     = s_tdata[47:40];
        res_in  = chg & CHAN_MASK & (~lvl | LANES'(1));
        rise_in = chg & CHAN_MASK & lvl;

        pick = pend_reg & (~pend_reg + LANES'(1));
        left = pend_reg & ~pick;
        chan = 3'd0;
        for (int i = 0; i < LANES; i++) begin
            if (pick[i]) begin
                chan = 3'(i);
            end
        end

        op_push  = hold_valid_reg && !qstat.full;
        s_tready = !hold_valid_reg || (op_push && (left == '0));
        accept   = s_tvalid && s_tready;

        op.kind    = ((chan == 3'd0) && rise0_reg) ? KIND_SLOT : KIND_HIGH;
        op.channel = chan;
        op.start   = (chan == 3'd0) ? start0_reg : start_reg[chan];
        op.now     = now_reg;
        op.last    = (left == '0);

        hold_valid_next = hold_valid_reg;
        pend_next       = pend_reg;
        now_next        = now_reg;
        start0_next     = start0_reg;
        rise0_next      = rise0_reg;
        start_next      = start_reg;

        if (op_push) begin
            pend_next       = left;
            hold_valid_next = (left != '0);
        end
        if (accept) begin
            hold_valid_next = (res_in != '0);
            pend_next       = res_in;
            now_next        = ts;
            start0_next     = start_reg[0];
            rise0_next      = rise_in[0];
            for (int i = 0; i < LANES; i++) begin
                if (rise_in[i]) begin
                    start_next[i] = ts;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            pend_reg       <= '0;
            for (int i = 0; i < LANES; i++) begin
                start_reg[i] <= '0;
            end
        end else begin
            hold_valid_reg <= hold_valid_next;
            pend_reg       <= pend_next;
            start_reg      <= start_next;
        end
        now_reg    <= now_next;
        start0_reg <= start0_next;
        rise0_reg  <= rise0_next;
    end

endmodule

FILE: hdl/mcpwc_queue.sv
// Short op queue between the front end and the width pipeline.
module mcpwc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mcpwc_pkg::op_t    wr_op,
    input  logic              pop,
    output mcpwc_pkg::op_t    rd_op,
    output mcpwc_pkg::qstat_t qstat
);
    import mcpwc_pkg::*;

    op_t            mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push, do_pop;

    always_comb begin
        qstat.full  = (count_reg == (QAW+1)'(QDEPTH));
        qstat.empty = (count_reg == '0);
        do_push     = push && !qstat.full;
        do_pop      = pop && !qstat.empty;
        count_next  = count_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        rd_op       = mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

FILE: hdl/mcpwc_back.sv
// Back end: span, divide by counts per microsecond, frame slot tracking, output register.
module mcpwc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  mcpwc_pkg::op_t    op,
    input  mcpwc_pkg::qstat_t qstat,
    output logic              pop,
    input  logic [31:0]       timer_period,
    input  logic [15:0]       sync_gap_us,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import mcpwc_pkg::*;

    logic        adv;
    logic        v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic        k1_reg, k2_reg, k3_reg, kind_reg;
    logic [2:0]  c1_reg, c2_reg, c3_reg, chan_reg;
    logic        l1_reg, l2_reg, l3_reg, last_reg;
    logic        n1_reg, n2_reg;
    logic [31:0] cnt1_reg, cnt2_reg, cnt3_reg;
    logic [31:0] q0_2_reg, q0_3_reg, qd3_reg;
    logic [31:0] width_reg;
    logic [2:0]  slot_reg, slot_idx_reg, slot_idx_next;

    logic [31:0] cnt_next, rem, width_next;
    logic [33:0] span_wide;
    logic        neg_next;
    logic [63:0] prod_recip, prod_div;
    logic        slot_wrap;

    always_comb begin
        adv = !m_valid_reg || m_tready;
        pop = adv && !qstat.empty;

        // a wrapped span below zero is taken as a 64-bit two's complement count
        span_wide = 34'(op.now) + 34'(timer_period) - 34'(op.start);
        neg_next  = 1'b0;
        if (op.start > op.now) begin
            cnt_next = span_wide[31:0];
            neg_next = span_wide[33];
        end else begin
            cnt_next = op.now - op.start;
        end

        prod_recip = 64'(cnt1_reg) * 64'(RECIP);
        prod_div   = 64'(q0_2_reg) * 64'(DIV1);

        // reciprocal estimate plus upper word remainder is low by at most three
        rem = cnt3_reg - qd3_reg;
        if (rem >= DIV3) begin
            width_next = q0_3_reg + 32'd3;
        end else if (rem >= DIV2) begin
            width_next = q0_3_reg + 32'd2;
        end else if (rem >= DIV1) begin
            width_next = q0_3_reg + 32'd1;
        end else begin
            width_next = q0_3_reg;
        end

        slot_wrap = (width_next > {16'd0, sync_gap_us}) ||
                    (({2'b00, slot_idx_reg} + 5'd1) >= SLOT_LIMIT);
        slot_idx_next = slot_idx_reg;
        if (adv && v3_reg && (k3_reg == KIND_SLOT)) begin
            slot_idx_next = slot_wrap ? 3'd0 : slot_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
            slot_idx_reg <= 3'd0;
        end else begin
            slot_idx_reg <= slot_idx_next;
            if (adv) begin
                v1_reg      <= pop;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                m_valid_reg <= v3_reg;
            end
        end
        if (adv) begin
            cnt1_reg  <= cnt_next;
            n1_reg    <= neg_next;
            k1_reg    <= op.kind;
            c1_reg    <= op.channel;
            l1_reg    <= op.last;

            q0_2_reg  <= prod_recip[63:32];
            cnt2_reg  <= cnt1_reg;
            n2_reg    <= n1_reg;
            k2_reg    <= k1_reg;
            c2_reg    <= c1_reg;
            l2_reg    <= l1_reg;

            qd3_reg   <= prod_div[31:0] - (n2_reg ? WRAP_R : 32'd0);
            q0_3_reg  <= q0_2_reg + (n2_reg ? WRAP_Q : 32'd0);
            cnt3_reg  <= cnt2_reg;
            k3_reg    <= k2_reg;
            c3_reg    <= c2_reg;
            l3_reg    <= l2_reg;

            width_reg <= width_next;
            kind_reg  <= k3_reg;
            chan_reg  <= c3_reg;
            last_reg  <= l3_reg;
            slot_reg  <= (k3_reg == KIND_SLOT) ? slot_idx_reg : 3'd0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, width_reg, slot_reg, chan_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: hdl/multi_channel_pulse_width_capture_core.sv
// Top level of the multi-channel pulse width capture core.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------------
//  s_        | in  | s_tvalid/s_tready  | tdata: timestamp, changed_mask, level_mask
//  m_        | out | m_tvalid/m_tready  | tdata: channel, slot, width_us; tuser kind; tlast
//  cfg_      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The front end emits one op per result of an event, one op per cycle while the 4-deep
// queue has room. The width pipeline takes one result per cycle unless stalled; an op
// passes the span, reciprocal, correction and output registers to m_tdata. Reset has
// no clearing pass. m_tready low stalls the pipeline; the queue absorbs up to 4 ops.
module multi_channel_pulse_width_capture_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] timestamp, [39:32] changed_mask, [47:40] level_mask
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] channel, [5:3] slot, [37:6] width_us, [39:38] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import mcpwc_pkg::*;

    op_t         front_op, queue_op;
    logic        op_push, op_pop;
    qstat_t      qstat;
    logic [31:0] timer_period_reg;
    logic [15:0] sync_gap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_period_reg <= TIMER_PERIOD_RST;
            sync_gap_reg     <= SYNC_GAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMER_PERIOD: timer_period_reg <= cfg_data;
                CFG_SYNC_GAP:     sync_gap_reg     <= cfg_data[15:0];
                default:          timer_period_reg <= timer_period_reg;
            endcase
        end
    end

    mcpwc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .op       (front_op),
        .op_push  (op_push),
        .qstat    (qstat)
    );

    mcpwc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (op_push),
        .wr_op   (front_op),
        .pop     (op_pop),
        .rd_op   (queue_op),
        .qstat   (qstat)
    );

    mcpwc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (queue_op),
        .qstat        (qstat),
        .pop          (op_pop),
        .timer_period (timer_period_reg),
        .sync_gap_us  (sync_gap_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    a_slot_on_ch0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SLOT) |-> m_tdata[2:0] == 3'd0)
        else $error("frame slot beat on nonzero channel");

    a_high_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_HIGH) |-> m_tdata[5:3] == 3'd0)
        else $error("high width beat with nonzero slot");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        op_push |-> !qstat.full)
        else $error("op pushed into full queue");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the multi-channel pulse width capture core.
`timescale 1ns / 100ps

module tb;
    import mcpwc_pkg::*;

    localparam int DRAIN_CYCLES  = 32;
    localparam int IDLE_LIMIT    = 5000;
    localparam int MAX_REPORTED  = 10;

    typedef struct packed {
        logic        kind;
        logic [2:0]  channel;
        logic [2:0]  slot;
        logic [31:0] width_us;
        logic        last;
    } capture_t;

    class capture_scoreboard;
        logic [31:0] start_time [LANES];
        logic [2:0]  slot_idx;
        logic [31:0] period;
        logic [15:0] sync_gap;
        capture_t    expected_captures [$];
        int          errors;

        function new();
            for (int c = 0; c < LANES; c++) start_time[c] = '0;
            slot_idx = '0;
            period   = TIMER_PERIOD_RST;
            sync_gap = SYNC_GAP_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == CFG_TIMER_PERIOD) period = data;
            else sync_gap = data[15:0];
        endfunction

        function logic [31:0] span_us(logic [31:0] start, logic [31:0] now);
            logic [63:0] counts;
            if (start > now) counts = 64'(now) + 64'(period) - 64'(start);
            else counts = 64'(now - start);
            return 32'(counts / 64'(COUNTS_PER_US));
        endfunction

        function void note_event(logic [31:0] now, logic [7:0] changed, logic [7:0] level);
            capture_t    r;
            logic [31:0] w;
            int          count;
            count = 0;
            for (int c = 0; c < NCH; c++) begin
                if (changed[c]) begin
                    if (level[c]) begin
                        if (c == 0) begin
                            w = span_us(start_time[0], now);
                            r = '{kind: KIND_SLOT, channel: 3'd0, slot: slot_idx,
                                  width_us: w, last: 1'b0};
                            expected_captures.push_back(r);
                            count++;
                            if (w > 32'(sync_gap) || int'(slot_idx) + 1 >= FRAME_SLOTS)
                                slot_idx = 3'd0;
                            else
                                slot_idx = slot_idx + 3'd1;
                        end
                        start_time[c] = now;
                    end else begin
                        r = '{kind: KIND_HIGH, channel: 3'(c), slot: 3'd0,
                              width_us: span_us(start_time[c], now), last: 1'b0};
                        expected_captures.push_back(r);
                        count++;
                    end
                end
            end
            if (count > 0) begin
                r = expected_captures.pop_back();
                r.last = 1'b1;
                expected_captures.push_back(r);
            end
        endfunction

        function void check_result(capture_t got);
            capture_t exp_r;
            if (expected_captures.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTED)
                    $display("unexpected beat: kind=%0d ch=%0d slot=%0d width=%0d last=%0d",
                             got.kind, got.channel, got.slot, got.width_us, got.last);
                return;
            end
            exp_r = expected_captures.pop_front();
            if (exp_r !== got) begin
                errors++;
                if (errors <= MAX_REPORTED)
                    $display("mismatch: exp kind=%0d ch=%0d slot=%0d width=%0d last=%0d, got kind=%0d ch=%0d slot=%0d width=%0d last=%0d",
                             exp_r.kind, exp_r.channel, exp_r.slot, exp_r.width_us, exp_r.last,
                             got.kind, got.channel, got.slot, got.width_us, got.last);
            end
        endfunction

        function int pending();
            return expected_captures.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_TIMER_PERIOD;
    logic [31:0] cfg_data  = '0;

    capture_scoreboard sb;

    logic [31:0] cur_ts;
    logic [7:0]  pin_level;
    logic [31:0] period_cfg;
    int          burst_left;

    int          rx_mode;
    int          rx_mode_left;
    int          rx_stall_left;
    int          rx_phase;
    int          idle_cycles;

    multi_channel_pulse_width_capture_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver back-pressure
    initial begin
        rx_mode       = 0;
        rx_mode_left  = 0;
        rx_stall_left = 0;
        rx_phase      = 0;
    end

    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ((rx_phase % 8) < 5);
            default: begin
                if (rx_stall_left != 0) begin
                    m_tready      <= 1'b0;
                    rx_stall_left <= rx_stall_left - 1;
                end else if ($urandom_range(0, 15) == 0) begin
                    m_tready      <= 1'b0;
                    rx_stall_left <= $urandom_range(5, 24);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{kind: m_tuser, channel: m_tdata[2:0], slot: m_tdata[5:3],
                              width_us: m_tdata[37:6], last: m_tlast});
    end

    initial idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_event(logic [31:0] ts, logic [7:0] changed, logic [7:0] level);
        s_tdata  <= {level, changed, ts};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_event(ts, changed, level);
        pin_level = (pin_level & ~changed) | (level & changed);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic set_config(logic [31:0] period, logic [15:0] gap);
        settle();
        write_reg(CFG_TIMER_PERIOD, period);
        write_reg(CFG_SYNC_GAP, {16'($urandom), gap});
        cfg_valid  <= 1'b0;
        period_cfg = period;
        cur_ts     = $urandom;
    endtask

    task automatic run_random(int n);
        logic [63:0] next_ts;
        logic [63:0] delta;
        logic [7:0]  changed;
        logic [7:0]  level;
        logic [31:0] ts;
        int          gap;
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            if ($urandom_range(0, 3) != 0) begin
                // well-formed pulse train: advancing timer, toggling pins
                case ($urandom_range(0, 9))
                    7, 8:    delta = 64'($urandom_range(2400, 6000)) * 64'(COUNTS_PER_US);
                    9:       delta = 64'($urandom_range(0, 100));
                    default: delta = 64'($urandom_range(800, 2200)) * 64'(COUNTS_PER_US);
                endcase
                next_ts = 64'(cur_ts) + delta;
                if (period_cfg >= 32'd100000) next_ts = next_ts % 64'(period_cfg);
                cur_ts = next_ts[31:0];
                ts = cur_ts;
                if ($urandom_range(0, 1) != 0) changed = 8'd1 << $urandom_range(0, 7);
                else changed = 8'($urandom_range(1, 255));
                level = pin_level ^ changed;
            end else begin
                ts      = $urandom;
                changed = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                level   = 8'($urandom_range(0, 255));
            end
            send_event(ts, changed, level);
        end
    endtask

    initial begin
        sb         = new();
        cur_ts     = '0;
        pin_level  = '0;
        period_cfg = TIMER_PERIOD_RST;
        burst_left = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset configuration
        send_event(32'd12345, 8'h00, 8'hFF);
        send_event(32'd72000, 8'h01, 8'h01);
        send_event(32'hFFFF_FFFF, 8'hFE, 8'h00);
        send_event(32'h0000_0010, 8'h01, 8'h01);
        cur_ts = 32'h10;
        repeat (9) begin
            cur_ts = cur_ts + 32'(1500 * COUNTS_PER_US);
            send_event(cur_ts, 8'h01, 8'h01);
        end
        cur_ts = cur_ts + 32'(2500 * COUNTS_PER_US);
        send_event(cur_ts, 8'h01, 8'h01);
        cur_ts = cur_ts + 32'(2501 * COUNTS_PER_US);
        send_event(cur_ts, 8'h01, 8'h01);
        cur_ts = cur_ts + 32'(700 * COUNTS_PER_US);
        send_event(cur_ts, 8'hFF, 8'hFF);
        cur_ts = cur_ts + 32'(1200 * COUNTS_PER_US);
        send_event(cur_ts, 8'hFF, 8'h00);
        send_event(32'h0000_0000, 8'hFF, 8'hFF);
        send_event(32'hFFFF_FFFF, 8'hFF, 8'h00);
        send_event(cur_ts, 8'hAA, 8'h55);
        send_event(cur_ts + 32'd5000, 8'h55, 8'hAA);

        set_config(TIMER_PERIOD_RST, SYNC_GAP_RST);
        run_random(40);
        set_config(32'd1, 16'd0);
        run_random(30);
        set_config($urandom_range(32'd1_000_000, 32'hFFFF_FFFE), 16'hFFFF);
        run_random(50);
        set_config($urandom_range(32'd1, 32'hFFFF_FFFF), 16'($urandom_range(0, 65535)));
        run_random(60);

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/mcpwc_pkg.sv
hdl/mcpwc_front.sv
hdl/mcpwc_queue.sv
hdl/mcpwc_back.sv
hdl/multi_channel_pulse_width_capture_core.sv
sim/tb.sv
